@@ sv/ihf_pkg.sv @@
// Shared types and constants for the IPv4 header framer.
package ihf_pkg;

	localparam int unsigned QUEUE_DEPTH = 4;
	localparam int unsigned HDR_BYTES   = 20;

	localparam logic [15:0] MAX_PAYLOAD = 16'd65515;
	localparam logic [15:0] IDENT_VALUE = 16'd54321;
	localparam logic [3:0]  IP_VERSION  = 4'd4;
	localparam logic [3:0]  IP_IHL      = 4'd5;
	localparam logic [7:0]  VER_IHL     = {IP_VERSION, IP_IHL};
	// constant header words folded into the checksum: version/IHL/TOS and identification
	localparam logic [17:0] CSUM_CONST  = 18'({VER_IHL, 8'h00}) + 18'(IDENT_VALUE);

	typedef enum logic {
		KIND_HEADER  = 1'b0,
		KIND_PAYLOAD = 1'b1
	} kind_t;

	typedef struct packed {
		kind_t       kind;
		logic [31:0] src_addr;
		logic [31:0] dst_addr;
		logic [7:0]  time_to_live;
		logic [7:0]  proto_number;
		logic [15:0] total_length;
		logic [16:0] csum_fold;
		logic        zero_len;
		logic [7:0]  payload_byte;
		logic        payload_end;
	} entry_t;

endpackage

@@ sv/ihf_front.sv @@
// Front end: accepts requests and payload bytes, tracks the remaining count, sums the header.
module ihf_front (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           s_tvalid,
	output logic           s_tready,
	input  logic [103:0]   s_tdata,  // src_addr, dst_addr, proto_number, time_to_live, payload_length, payload_byte
	input  logic [0:0]     s_tuser,  // mode
	output logic           push_valid,
	input  logic           push_ready,
	output ihf_pkg::entry_t push_data
);
	import ihf_pkg::*;

	logic [31:0] in_src;
	logic [31:0] in_dst;
	logic [7:0]  in_proto;
	logic [7:0]  in_ttl;
	logic [15:0] in_plen;
	logic [7:0]  in_byte;
	logic        in_hdr;
	logic [15:0] plen_sat;
	logic [15:0] total;
	logic        accept;
	logic        keep;

	logic [15:0] rem_q;
	logic        valid_s1;
	kind_t       kind_s1;
	logic [31:0] src_s1;
	logic [31:0] dst_s1;
	logic [7:0]  ttl_s1;
	logic [7:0]  proto_s1;
	logic [15:0] total_s1;
	logic        zlen_s1;
	logic [7:0]  byte_s1;
	logic        pend_s1;
	logic [17:0] suma_s1;
	logic [17:0] sumb_s1;

	logic [18:0] sum_full;
	logic [16:0] sum_fold;

	assign in_src   = s_tdata[31:0];
	assign in_dst   = s_tdata[63:32];
	assign in_proto = s_tdata[71:64];
	assign in_ttl   = s_tdata[79:72];
	assign in_plen  = s_tdata[95:80];
	assign in_byte  = s_tdata[103:96];
	assign in_hdr   = (kind_t'(s_tuser[0]) == KIND_HEADER);

	assign plen_sat = (in_plen > MAX_PAYLOAD) ? MAX_PAYLOAD : in_plen;
	assign total    = plen_sat + 16'(HDR_BYTES);

	assign s_tready = !valid_s1 || push_ready;
	assign accept   = s_tvalid && s_tready;
	assign keep     = in_hdr || (rem_q != 16'd0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_q    <= '0;
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= keep;
			if (in_hdr) begin
				rem_q <= plen_sat;
			end else if (rem_q != 16'd0) begin
				rem_q <= rem_q - 16'd1;
			end
		end else if (push_ready) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			kind_s1  <= in_hdr ? KIND_HEADER : KIND_PAYLOAD;
			src_s1   <= in_src;
			dst_s1   <= in_dst;
			ttl_s1   <= in_ttl;
			proto_s1 <= in_proto;
			total_s1 <= total;
			zlen_s1  <= (plen_sat == 16'd0);
			byte_s1  <= in_byte;
			pend_s1  <= (rem_q == 16'd1);
			suma_s1  <= 18'(in_src[31:16]) + 18'(in_src[15:0])
				+ 18'(in_dst[31:16]) + 18'(in_dst[15:0]);
			sumb_s1  <= 18'({in_ttl, in_proto}) + 18'(total) + CSUM_CONST;
		end
	end

	assign sum_full = 19'(suma_s1) + 19'(sumb_s1);
	assign sum_fold = 17'(sum_full[15:0]) + 17'(sum_full[18:16]);

	assign push_valid = valid_s1;

	always_comb begin
		push_data              = '0;
		push_data.kind         = kind_s1;
		push_data.src_addr     = src_s1;
		push_data.dst_addr     = dst_s1;
		push_data.time_to_live = ttl_s1;
		push_data.proto_number = proto_s1;
		push_data.total_length = total_s1;
		push_data.csum_fold    = sum_fold;
		push_data.zero_len     = zlen_s1;
		push_data.payload_byte = byte_s1;
		push_data.payload_end  = pend_s1;
	end

endmodule

@@ sv/ihf_queue.sv @@
// Short register queue between the front end and the byte serializer.
module ihf_queue #(
	parameter int unsigned DEPTH = ihf_pkg::QUEUE_DEPTH
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push_valid,
	output logic            push_ready,
	input  ihf_pkg::entry_t push_data,
	output logic            pop_valid,
	input  logic            pop_ready,
	output ihf_pkg::entry_t pop_data
);
	import ihf_pkg::*;

	localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CW = $clog2(DEPTH + 1);
	localparam logic [PW-1:0] PTR_LAST = PW'(DEPTH - 1);
	localparam logic [CW-1:0] CNT_FULL = CW'(DEPTH);

	entry_t        slot_q [DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;
	logic          do_push;
	logic          do_pop;

	assign push_ready = (count_q != CNT_FULL);
	assign pop_valid  = (count_q != '0);
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;
	assign pop_data   = slot_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + PW'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + PW'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + CW'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

@@ sv/ihf_back.sv @@
// Back end: serializes headers byte by byte, passes payload bytes, drives the output register.
module ihf_back (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            pop_valid,
	output logic            pop_ready,
	input  ihf_pkg::entry_t pop_data,
	output logic            m_tvalid,
	input  logic            m_tready,
	output logic [7:0]      m_tdata,  // out_byte
	output logic [0:0]      m_tuser,  // run_last
	output logic            m_tlast
);
	import ihf_pkg::*;

	localparam logic [4:0] IDX_LAST = 5'(HDR_BYTES - 1);

	logic        busy_q;
	logic [4:0]  idx_q;
	logic [31:0] src_q;
	logic [31:0] dst_q;
	logic [7:0]  ttl_q;
	logic [7:0]  proto_q;
	logic [15:0] total_q;
	logic        zlen_q;
	logic [15:0] ck_q;
	logic        out_valid_q;
	logic [7:0]  out_byte_q;
	logic        out_run_q;
	logic        out_end_q;

	logic        adv;
	logic        hdr_last;
	logic [7:0]  hdr_byte;
	logic [15:0] ck_sum;

	assign adv       = !out_valid_q || m_tready;
	assign pop_ready = adv && !busy_q;
	assign hdr_last  = (idx_q == IDX_LAST);
	assign ck_sum    = pop_data.csum_fold[15:0] + 16'(pop_data.csum_fold[16]);

	always_comb begin
		unique case (idx_q)
			5'd0:    hdr_byte = VER_IHL;
			5'd1:    hdr_byte = 8'h00;
			5'd2:    hdr_byte = total_q[15:8];
			5'd3:    hdr_byte = total_q[7:0];
			5'd4:    hdr_byte = IDENT_VALUE[15:8];
			5'd5:    hdr_byte = IDENT_VALUE[7:0];
			5'd6:    hdr_byte = 8'h00;
			5'd7:    hdr_byte = 8'h00;
			5'd8:    hdr_byte = ttl_q;
			5'd9:    hdr_byte = proto_q;
			5'd10:   hdr_byte = ck_q[15:8];
			5'd11:   hdr_byte = ck_q[7:0];
			5'd12:   hdr_byte = src_q[31:24];
			5'd13:   hdr_byte = src_q[23:16];
			5'd14:   hdr_byte = src_q[15:8];
			5'd15:   hdr_byte = src_q[7:0];
			5'd16:   hdr_byte = dst_q[31:24];
			5'd17:   hdr_byte = dst_q[23:16];
			5'd18:   hdr_byte = dst_q[15:8];
			5'd19:   hdr_byte = dst_q[7:0];
			default: hdr_byte = 8'h00;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else if (adv) begin
			if (busy_q) begin
				out_valid_q <= 1'b1;
				idx_q       <= idx_q + 5'd1;
				if (hdr_last) begin
					busy_q <= 1'b0;
				end
			end else if (pop_valid) begin
				out_valid_q <= 1'b1;
				if (pop_data.kind == KIND_HEADER) begin
					busy_q <= 1'b1;
					idx_q  <= 5'd1;
				end
			end else begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			if (busy_q) begin
				out_byte_q <= hdr_byte;
				out_run_q  <= hdr_last;
				out_end_q  <= hdr_last && zlen_q;
			end else if (pop_valid) begin
				if (pop_data.kind == KIND_HEADER) begin
					out_byte_q <= VER_IHL;
					out_run_q  <= 1'b0;
					out_end_q  <= 1'b0;
					src_q      <= pop_data.src_addr;
					dst_q      <= pop_data.dst_addr;
					ttl_q      <= pop_data.time_to_live;
					proto_q    <= pop_data.proto_number;
					total_q    <= pop_data.total_length;
					zlen_q     <= pop_data.zero_len;
					ck_q       <= ~ck_sum;
				end else begin
					out_byte_q <= pop_data.payload_byte;
					out_run_q  <= 1'b1;
					out_end_q  <= pop_data.payload_end;
				end
			end
		end
	end

	assign m_tvalid   = out_valid_q;
	assign m_tdata    = out_byte_q;
	assign m_tuser[0] = out_run_q;
	assign m_tlast    = out_end_q;

endmodule

@@ sv/ipv4_header_framer_core.sv @@
// Top level of the IPv4 header framer: front end, request queue and byte serializer.
//
// Takes header requests (tuser 0) and payload bytes (tuser 1) on the slave stream and
// emits the packet byte by byte in wire order on the master stream. A header request
// produces the 20 header bytes, checksum included; the serializer in the back end emits
// one byte per cycle while m_tready does not stall it, and takes no new queue entry
// while a header is being emitted. The front end accepts one transaction per cycle as
// long as the queue (QUEUE_DEPTH entries) has room, and stalls when a run of headers
// fills it. The first output byte of a transaction goes through the front-end register,
// a queue slot and the output register before it is valid on the master stream.
// tuser on the output flags the last byte caused by one input transaction, tlast the
// final byte of the packet. Payload bytes beyond the requested length are dropped.
module ipv4_header_framer_core #(
	parameter int unsigned QUEUE_DEPTH = ihf_pkg::QUEUE_DEPTH
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [103:0] s_tdata,  // src_addr, dst_addr, proto_number, time_to_live, payload_length, payload_byte
	input  logic [0:0]   s_tuser,  // mode
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [7:0]   m_tdata,  // out_byte
	output logic [0:0]   m_tuser,  // run_last
	output logic         m_tlast
);
	import ihf_pkg::*;

	logic   push_valid;
	logic   push_ready;
	entry_t push_data;
	logic   pop_valid;
	logic   pop_ready;
	entry_t pop_data;

	ihf_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.s_tuser    (s_tuser),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_data  (push_data)
	);

	ihf_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_data  (push_data),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_data   (pop_data)
	);

	ihf_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.pop_valid (pop_valid),
		.pop_ready (pop_ready),
		.pop_data  (pop_data),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.m_tlast   (m_tlast)
	);

endmodule

@@ verif/tb_ipv4_header_framer_core.sv @@
`timescale 1ns / 100ps
// Self-checking stream testbench for ipv4_header_framer_core, with its own packet predictor.
module tb_ipv4_header_framer_core;
	import ihf_pkg::*;

	localparam int unsigned RUN_LIMIT    = 500000;
	localparam int unsigned HOLD_CYCLES  = 200;
	localparam int unsigned DRAIN_CYCLES = 40;

	typedef struct {
		kind_t       kind;
		logic [31:0] src_addr;
		logic [31:0] dst_addr;
		logic [7:0]  proto_number;
		logic [7:0]  time_to_live;
		logic [15:0] payload_length;
		logic [7:0]  payload_byte;
	} request_t;

	typedef struct {
		logic [7:0] data;
		logic       run_last;
		logic       packet_end;
	} wire_byte_t;

	logic         clk;
	logic         arst_n;
	logic         s_tvalid;
	logic         s_tready;
	logic [103:0] s_tdata;
	logic [0:0]   s_tuser;
	logic         m_tvalid;
	logic         m_tready;
	logic [7:0]   m_tdata;
	logic [0:0]   m_tuser;
	logic         m_tlast;

	request_t    drv_req;
	request_t    req_backlog[$];
	wire_byte_t  wire_bytes_due[$];

	logic [15:0] payload_left;
	logic [15:0] gen_left;
	int unsigned gen_items;
	logic        in_taken;
	logic        calm;
	int unsigned tx_gap;
	int unsigned rx_gap;
	int unsigned hold_left;
	int unsigned hold_requests;
	int unsigned hold_served;
	int unsigned cycle_count;
	int unsigned fail_count;
	int unsigned headers_seen;
	int unsigned payload_passed;
	int unsigned payload_dropped;
	int unsigned bytes_checked;
	int unsigned packets_closed;
	int unsigned input_stalls;

	assign s_tdata = {drv_req.payload_byte, drv_req.payload_length, drv_req.time_to_live,
		drv_req.proto_number, drv_req.dst_addr, drv_req.src_addr};
	assign s_tuser = drv_req.kind;

	ipv4_header_framer_core uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	function automatic int unsigned pick_gap();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (calm || r < 60)
			return 0;
		if (r < 93)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	task automatic note_error(input string msg);
		fail_count++;
		if (fail_count <= 10)
			$display("ERROR @%0t: %s", $realtime, msg);
	endtask

	// expected wire bytes for one accepted transaction
	task automatic frame_request(input request_t r);
		logic [7:0]  hdr [HDR_BYTES];
		logic [15:0] plen;
		logic [15:0] total;
		logic [31:0] sum;
		wire_byte_t  wb;
		if (r.kind == KIND_HEADER) begin
			plen = (r.payload_length > MAX_PAYLOAD) ? MAX_PAYLOAD : r.payload_length;
			total = plen + 16'(HDR_BYTES);
			hdr[0] = VER_IHL;
			hdr[1] = 8'h00;
			hdr[2] = total[15:8];
			hdr[3] = total[7:0];
			hdr[4] = IDENT_VALUE[15:8];
			hdr[5] = IDENT_VALUE[7:0];
			hdr[6] = 8'h00;
			hdr[7] = 8'h00;
			hdr[8] = r.time_to_live;
			hdr[9] = r.proto_number;
			hdr[10] = 8'h00;
			hdr[11] = 8'h00;
			for (int i = 0; i < 4; i++) begin
				hdr[12 + i] = r.src_addr[31 - 8 * i -: 8];
				hdr[16 + i] = r.dst_addr[31 - 8 * i -: 8];
			end
			sum = 32'd0;
			for (int i = 0; i < HDR_BYTES; i += 2)
				sum += {16'h0000, hdr[i], hdr[i + 1]};
			sum = (sum >> 16) + (sum & 32'h0000ffff);
			sum += sum >> 16;
			hdr[10] = ~sum[15:8];
			hdr[11] = ~sum[7:0];
			for (int i = 0; i < HDR_BYTES; i++) begin
				wb.data = hdr[i];
				wb.run_last = (i == HDR_BYTES - 1);
				wb.packet_end = wb.run_last && (plen == 16'd0);
				wire_bytes_due.push_back(wb);
			end
			payload_left = plen;
			headers_seen++;
		end else if (payload_left == 16'd0) begin
			payload_dropped++;
		end else begin
			payload_left = payload_left - 16'd1;
			wb.data = r.payload_byte;
			wb.run_last = 1'b1;
			wb.packet_end = (payload_left == 16'd0);
			wire_bytes_due.push_back(wb);
			payload_passed++;
		end
	endtask

	task automatic push_header(input logic [31:0] src, input logic [31:0] dst,
		input logic [7:0] proto, input logic [7:0] ttl, input logic [15:0] plen);
		request_t r;
		r.kind = KIND_HEADER;
		r.src_addr = src;
		r.dst_addr = dst;
		r.proto_number = proto;
		r.time_to_live = ttl;
		r.payload_length = plen;
		r.payload_byte = 8'($urandom);
		req_backlog.push_back(r);
		gen_left = (plen > MAX_PAYLOAD) ? MAX_PAYLOAD : plen;
		gen_items++;
	endtask

	task automatic push_payload(input logic [7:0] data);
		request_t r;
		r.kind = KIND_PAYLOAD;
		r.src_addr = $urandom;
		r.dst_addr = $urandom;
		r.proto_number = 8'($urandom);
		r.time_to_live = 8'($urandom);
		r.payload_length = 16'($urandom);
		r.payload_byte = data;
		req_backlog.push_back(r);
		if (gen_left != 16'd0) begin
			gen_left = gen_left - 16'd1;
			gen_items++;
		end
	endtask

	// mostly complete packets; some cut short by the next header, some with stray bytes
	task automatic push_random_packet();
		int unsigned sel;
		int unsigned plen;
		int unsigned nbytes;
		sel = $urandom_range(0, 99);
		if (sel < 80)
			plen = $urandom_range(0, 8);
		else if (sel < 90)
			plen = $urandom_range(9, 40);
		else
			plen = $urandom_range(0, 65535);
		push_header($urandom, $urandom, 8'($urandom), 8'($urandom), 16'(plen));
		nbytes = (plen > 40) ? $urandom_range(0, 6) : plen;
		sel = $urandom_range(0, 99);
		if (sel < 15 && nbytes != 0)
			nbytes = $urandom_range(0, nbytes - 1);
		else if (sel < 30)
			nbytes += $urandom_range(1, 3);
		repeat (nbytes)
			push_payload(8'($urandom));
	endtask

	task automatic wait_backlog_empty();
		while (req_backlog.size() != 0 || s_tvalid)
			@(posedge clk);
	endtask

	// driver
	always @(negedge clk) begin
		if (arst_n) begin
			if (s_tvalid && !in_taken) begin
				// keep offering the current transaction
			end else if (tx_gap != 0) begin
				tx_gap <= tx_gap - 1;
				s_tvalid <= 1'b0;
			end else if (req_backlog.size() != 0) begin
				drv_req <= req_backlog.pop_front();
				s_tvalid <= 1'b1;
				tx_gap <= pick_gap();
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	// receiver
	always @(negedge clk) begin
		if (arst_n) begin
			if (hold_left != 0) begin
				m_tready <= 1'b0;
			end else if (rx_gap != 0) begin
				rx_gap <= rx_gap - 1;
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
				rx_gap <= pick_gap();
			end
		end
	end

	// long receiver hold-off
	always @(negedge clk) begin
		if (hold_left != 0) begin
			hold_left <= hold_left - 1;
		end else if (hold_served != hold_requests) begin
			hold_left <= HOLD_CYCLES;
			hold_served <= hold_served + 1;
		end
	end

	// monitor and predictor
	always @(posedge clk) begin
		wire_byte_t wb;
		in_taken <= arst_n && s_tvalid && s_tready;
		if (arst_n && s_tvalid && !s_tready)
			input_stalls++;
		if (arst_n && s_tvalid && s_tready)
			frame_request(drv_req);
		if (arst_n && m_tvalid && m_tready) begin
			bytes_checked++;
			if (m_tlast)
				packets_closed++;
			if (wire_bytes_due.size() == 0) begin
				note_error($sformatf("unexpected transaction: byte %02h run_last %0d end %0d",
					m_tdata, m_tuser, m_tlast));
			end else begin
				wb = wire_bytes_due.pop_front();
				if (m_tdata !== wb.data || m_tuser[0] !== wb.run_last
					|| m_tlast !== wb.packet_end)
					note_error($sformatf({"byte %02h run_last %0d end %0d,",
						" expected byte %02h run_last %0d end %0d"},
						m_tdata, m_tuser, m_tlast, wb.data, wb.run_last, wb.packet_end));
			end
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == RUN_LIMIT) begin
			$display("Timeout after %0d cycles, %0d bytes still expected",
				cycle_count, wire_bytes_due.size());
			$display("DONE: errors detected");
			$finish;
		end
	end

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		m_tready = 1'b0;
		drv_req = '{KIND_HEADER, 32'd0, 32'd0, 8'd0, 8'd0, 16'd0, 8'd0};
		payload_left = 16'd0;
		gen_left = 16'd0;
		gen_items = 0;
		in_taken = 1'b0;
		calm = 1'b0;
		tx_gap = 0;
		rx_gap = 0;
		hold_left = 0;
		hold_requests = 0;
		hold_served = 0;
		cycle_count = 0;
		fail_count = 0;
		headers_seen = 0;
		payload_passed = 0;
		payload_dropped = 0;
		bytes_checked = 0;
		packets_closed = 0;
		input_stalls = 0;
		repeat (8) @(posedge clk);
		@(negedge clk) arst_n <= 1'b1;

		// directed: field extremes, empty payload, saturation, drops, header mid-payload
		push_payload(8'ha5);
		push_header(32'h0, 32'h0, 8'h00, 8'h00, 16'd0);
		push_payload(8'h00);
		push_header(32'hffffffff, 32'hffffffff, 8'hff, 8'hff, 16'hffff);
		push_payload(8'hff);
		push_payload(8'h00);
		push_header(32'h80000001, 32'h7ffffffe, 8'h06, 8'h40, MAX_PAYLOAD);
		push_payload(8'h5a);
		push_header(32'h01020304, 32'hc0a80001, 8'h11, 8'h01, MAX_PAYLOAD + 16'd1);
		push_header($urandom, $urandom, 8'($urandom), 8'($urandom), 16'd1);
		push_payload(8'h3c);
		push_payload(8'hc3);
		push_header($urandom, $urandom, 8'($urandom), 8'($urandom), 16'd2);
		push_payload(8'h01);
		push_payload(8'h80);
		push_payload(8'h7f);
		push_header($urandom, $urandom, 8'($urandom), 8'($urandom), 16'd3);
		push_payload(8'h55);
		push_header($urandom, $urandom, 8'($urandom), 8'($urandom), 16'd0);
		push_header($urandom, $urandom, 8'($urandom), 8'($urandom), 16'h8000);
		push_payload(8'haa);
		push_header($urandom, $urandom, 8'($urandom), 8'($urandom), 16'h7fff);
		push_payload(8'h99);
		wait_backlog_empty();

		// random traffic with a long receiver hold-off so the input backs up
		while (gen_items < 60)
			push_random_packet();
		@(posedge clk) hold_requests <= hold_requests + 1;
		wait_backlog_empty();

		calm = 1'b1;
		while (gen_items < 95)
			push_random_packet();
		wait_backlog_empty();

		calm = 1'b0;
		while (gen_items < 135)
			push_random_packet();
		wait_backlog_empty();

		while (wire_bytes_due.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (wire_bytes_due.size() != 0)
			note_error($sformatf("%0d bytes never arrived", wire_bytes_due.size()));

		$display("Run covered %0d header requests, %0d payload bytes forwarded, %0d dropped.",
			headers_seen, payload_passed, payload_dropped);
		$display("Checked %0d output bytes, %0d packet ends; input stalled on %0d cycles.",
			bytes_checked, packets_closed, input_stalls);
		if (fail_count == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule

@@ filelist.f @@
sv/ihf_pkg.sv
sv/ihf_front.sv
sv/ihf_queue.sv
sv/ihf_back.sv
sv/ipv4_header_framer_core.sv
verif/tb_ipv4_header_framer_core.sv
